### src/llsf_pkg.sv
package llsf_pkg;

    // Fixed field widths of the sample and result transactions
    localparam int SAMPLE_W    = 16;
    localparam int RESULT_W    = 48;
    localparam int COUNT_OUT_W = 11;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_value;
        logic signed [SAMPLE_W-1:0] y_value;
        logic                       last_point;
    } t_sample;

    typedef struct packed {
        logic signed [RESULT_W-1:0] intercept;
        logic signed [RESULT_W-1:0] slope;
        logic                       singular;
        logic                       overflowed;
        logic [COUNT_OUT_W-1:0]     points_used;
    } t_fit_result;

endpackage

### src/llsf_div.sv
module llsf_div #(
    parameter int NUM_W  = 87,
    parameter int FRAC_W = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_neg,
    input  logic [NUM_W-1:0]                      i_num,
    input  logic [NUM_W-1:0]                      i_den,
    output logic                                  o_done,
    output logic signed [llsf_pkg::RESULT_W-1:0] o_quot
);
    import llsf_pkg::*;

    // Restoring divider, one quotient bit per cycle. The numerator magnitude
    // is fed MSB first, followed by FRAC_W zero bits for the fraction.
    localparam int STEPS = NUM_W + FRAC_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    r_den;
    logic [NUM_W-1:0]    r_rem;
    logic [RESULT_W-1:0] r_q;
    logic                r_sticky;
    logic                r_neg;
    logic                r_run;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;

    logic [NUM_W:0]      rem_sh;
    logic [NUM_W:0]      rem_diff;
    logic                fits;
    logic [NUM_W-1:0]    n_rem;
    logic                over;
    logic [RESULT_W-1:0] mag;

    assign rem_sh   = {r_rem, r_num[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign fits     = (rem_sh >= {1'b0, r_den});
    assign n_rem    = fits ? rem_diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];

    // Saturation: bits shifted past the top of r_q land in the sticky flag
    assign over = r_sticky
                | (r_neg ? (r_q[RESULT_W-1] & (|r_q[RESULT_W-2:0])) : r_q[RESULT_W-1]);
    assign mag  = over ? (r_neg ? {1'b1, {(RESULT_W-1){1'b0}}} : {1'b0, {(RESULT_W-1){1'b1}}})
                       : r_q;
    assign o_quot = $signed(r_neg ? (~mag + 1'b1) : mag);
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(STEPS);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num    <= i_num;
            r_den    <= i_den;
            r_rem    <= '0;
            r_q      <= '0;
            r_sticky <= 1'b0;
            r_neg    <= i_neg;
        end else if (r_run) begin
            r_num    <= {r_num[NUM_W-2:0], 1'b0};
            r_rem    <= n_rem;
            r_q      <= {r_q[RESULT_W-2:0], fits};
            r_sticky <= r_sticky | r_q[RESULT_W-1];
        end
    end

endmodule

### src/linear_least_squares_fit_core.sv
// Least-squares line fit over a stream of (x, y) samples. A sample transaction
// is taken when start is high and busy is low; each pair adds into running sums
// of x, y, x*y and x*x, with the products built bit-serially, so a pair that
// enters the sums keeps busy high until its products are in the sums. A pair
// arriving with the count already at MAX_POINTS is dropped and sets the
// overflow flag. The pair marked last_point triggers the fit: the three cross
// products are formed by a bit-serial multiplier per term, then two restoring
// dividers run side by side, one quotient bit per cycle. When the set is
// singular the dividers do not run, and a last pair dropped at capacity goes
// to the fit without forming its products. The result on o_result is flagged
// by o_result_valid, high for exactly one cycle; the receiver cannot hold it
// off, so it must capture it in that cycle. busy drops in that same cycle,
// and all sums, the count and the overflow flag are cleared for the next set.
module linear_least_squares_fit_core #(
    parameter int MAX_POINTS       = 1024,
    parameter int RESULT_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  llsf_pkg::t_sample     i_sample,
    output logic                  o_result_valid,
    output llsf_pkg::t_fit_result o_result
);
    import llsf_pkg::*;

    // Sum widths grow with the count so the running sums never wrap
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int SUM1_W    = SAMPLE_W + CNT_W;
    localparam int SUM2_W    = 2 * SAMPLE_W + CNT_W;
    localparam int OPND_W    = SUM2_W;
    // Difference of two OPND_W x OPND_W products
    localparam int WIDE_W    = 2 * OPND_W + 1;
    localparam int BIT_W     = $clog2(OPND_W);
    localparam int NUM_LANES = 3;

    // One serial multiply lane per term of the fit
    localparam int LANE_DEN   = 0;  // n*Sxx - Sx*Sx
    localparam int LANE_SLOPE = 1;  // n*Sxy - Sx*Sy
    localparam int LANE_ICPT  = 2;  // Sxx*Sy - Sx*Sxy

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_LOAD,
        S_PROD,
        S_ABS,
        S_DIV
    } t_state;

    // Control and running state
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_full, n_full;
    logic                      r_last, n_last;
    logic [BIT_W-1:0]          r_bit, n_bit;
    logic                      r_phase, n_phase;
    logic                      r_out_valid, n_out_valid;
    logic signed [SUM1_W-1:0]  r_sum_x, n_sum_x;
    logic signed [SUM1_W-1:0]  r_sum_y, n_sum_y;
    logic signed [SUM2_W-1:0]  r_sum_xy, n_sum_xy;
    logic signed [SUM2_W-1:0]  r_sum_xx, n_sum_xx;

    // Datapath shift registers
    logic signed [SUM2_W-1:0]   r_mac_mcand, n_mac_mcand;
    logic [SAMPLE_W-1:0]        r_mac_mult_y, n_mac_mult_y;
    logic [SAMPLE_W-1:0]        r_mac_mult_x, n_mac_mult_x;
    logic signed [WIDE_W-1:0]   r_mcand [NUM_LANES];
    logic signed [WIDE_W-1:0]   n_mcand [NUM_LANES];
    logic [OPND_W-1:0]          r_mult  [NUM_LANES];
    logic [OPND_W-1:0]          n_mult  [NUM_LANES];
    logic signed [WIDE_W-1:0]   r_acc   [NUM_LANES];
    logic signed [WIDE_W-1:0]   n_acc   [NUM_LANES];
    logic signed [WIDE_W-1:0]   lane_next [NUM_LANES];
    t_fit_result                r_out, n_out;

    // Operands of the fit, all at OPND_W
    logic signed [OPND_W-1:0] op_n;
    logic signed [OPND_W-1:0] op_sx;
    logic signed [OPND_W-1:0] op_sy;
    logic signed [OPND_W-1:0] op_sxy;
    logic signed [OPND_W-1:0] op_sxx;

    logic                     mac_msb;
    logic                     prod_msb;
    logic [SUM2_W-1:0]        mac_add_xy;
    logic [SUM2_W-1:0]        mac_add_xx;

    // Sign and magnitude ahead of the dividers
    logic                     den_zero;
    logic                     den_neg;
    logic [WIDE_W-1:0]        den_mag;
    logic [WIDE_W-1:0]        slope_mag;
    logic [WIDE_W-1:0]        icpt_mag;
    logic                     div_start;
    logic                     div_slope_done;
    logic                     div_icpt_done;
    logic signed [RESULT_W-1:0] quot_slope;
    logic signed [RESULT_W-1:0] quot_icpt;

    assign op_n   = $signed(OPND_W'(r_count));
    assign op_sx  = OPND_W'(r_sum_x);
    assign op_sy  = OPND_W'(r_sum_y);
    assign op_sxy = r_sum_xy;
    assign op_sxx = r_sum_xx;

    // Two's complement multiply: the top bit of the multiplier weighs negative
    assign mac_msb    = (r_bit == BIT_W'(SAMPLE_W - 1));
    assign prod_msb   = (r_bit == BIT_W'(OPND_W - 1));
    assign mac_add_xy = r_mac_mult_y[0] ? r_mac_mcand : '0;
    assign mac_add_xx = r_mac_mult_x[0] ? r_mac_mcand : '0;

    // Second product of each lane is subtracted, hence the phase term
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (r_phase ^ prod_msb) begin
                lane_next[l] = r_acc[l] - (r_mult[l][0] ? r_mcand[l] : '0);
            end else begin
                lane_next[l] = r_acc[l] + (r_mult[l][0] ? r_mcand[l] : '0);
            end
        end
    end

    assign den_zero  = (r_acc[LANE_DEN] == '0);
    assign den_neg   = r_acc[LANE_DEN][WIDE_W-1];
    assign den_mag   = den_neg ? (~r_acc[LANE_DEN] + 1'b1) : r_acc[LANE_DEN];
    assign slope_mag = r_acc[LANE_SLOPE][WIDE_W-1] ? (~r_acc[LANE_SLOPE] + 1'b1)
                                                   : r_acc[LANE_SLOPE];
    assign icpt_mag  = r_acc[LANE_ICPT][WIDE_W-1] ? (~r_acc[LANE_ICPT] + 1'b1)
                                                  : r_acc[LANE_ICPT];
    assign div_start = (r_state == S_ABS) && !den_zero;

    llsf_div #(
        .NUM_W  (WIDE_W),
        .FRAC_W (RESULT_FRAC_BITS)
    ) u_div_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_neg   (r_acc[LANE_SLOPE][WIDE_W-1] ^ den_neg),
        .i_num   (slope_mag),
        .i_den   (den_mag),
        .o_done  (div_slope_done),
        .o_quot  (quot_slope)
    );

    llsf_div #(
        .NUM_W  (WIDE_W),
        .FRAC_W (RESULT_FRAC_BITS)
    ) u_div_icpt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_neg   (r_acc[LANE_ICPT][WIDE_W-1] ^ den_neg),
        .i_num   (icpt_mag),
        .i_den   (den_mag),
        .o_done  (div_icpt_done),
        .o_quot  (quot_icpt)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_full       = r_full;
        n_last       = r_last;
        n_bit        = r_bit;
        n_phase      = r_phase;
        n_out_valid  = 1'b0;
        n_sum_x      = r_sum_x;
        n_sum_y      = r_sum_y;
        n_sum_xy     = r_sum_xy;
        n_sum_xx     = r_sum_xx;
        n_mac_mcand  = r_mac_mcand;
        n_mac_mult_y = r_mac_mult_y;
        n_mac_mult_x = r_mac_mult_x;
        n_mcand      = r_mcand;
        n_mult       = r_mult;
        n_acc        = r_acc;
        n_out        = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_last = i_sample.last_point;
                    if (r_count < CNT_W'(MAX_POINTS)) begin
                        n_sum_x      = r_sum_x + SUM1_W'(i_sample.x_value);
                        n_sum_y      = r_sum_y + SUM1_W'(i_sample.y_value);
                        n_count      = r_count + 1'b1;
                        n_mac_mcand  = SUM2_W'(i_sample.x_value);
                        n_mac_mult_y = i_sample.y_value;
                        n_mac_mult_x = i_sample.x_value;
                        n_bit        = '0;
                        n_state      = S_MAC;
                    end else begin
                        // dropped pair; its last mark still closes the set
                        n_full = 1'b1;
                        if (i_sample.last_point) begin
                            n_state = S_LOAD;
                        end
                    end
                end
            end

            S_MAC: begin
                // x*y and x*x, one multiplier bit per cycle, straight into the sums
                n_sum_xy     = mac_msb ? r_sum_xy - mac_add_xy : r_sum_xy + mac_add_xy;
                n_sum_xx     = mac_msb ? r_sum_xx - mac_add_xx : r_sum_xx + mac_add_xx;
                n_mac_mcand  = {r_mac_mcand[SUM2_W-2:0], 1'b0};
                n_mac_mult_y = {1'b0, r_mac_mult_y[SAMPLE_W-1:1]};
                n_mac_mult_x = {1'b0, r_mac_mult_x[SAMPLE_W-1:1]};
                n_bit        = r_bit + 1'b1;
                if (mac_msb) begin
                    n_state = r_last ? S_LOAD : S_IDLE;
                end
            end

            S_LOAD: begin
                n_mcand[LANE_DEN]   = WIDE_W'(op_n);
                n_mult[LANE_DEN]    = op_sxx;
                n_mcand[LANE_SLOPE] = WIDE_W'(op_n);
                n_mult[LANE_SLOPE]  = op_sxy;
                n_mcand[LANE_ICPT]  = WIDE_W'(op_sy);
                n_mult[LANE_ICPT]   = op_sxx;
                for (int l = 0; l < NUM_LANES; l++) begin
                    n_acc[l] = '0;
                end
                n_bit   = '0;
                n_phase = 1'b0;
                n_state = S_PROD;
            end

            S_PROD: begin
                n_acc = lane_next;
                for (int l = 0; l < NUM_LANES; l++) begin
                    n_mcand[l] = {r_mcand[l][WIDE_W-2:0], 1'b0};
                    n_mult[l]  = {1'b0, r_mult[l][OPND_W-1:1]};
                end
                n_bit = r_bit + 1'b1;
                if (prod_msb) begin
                    n_bit = '0;
                    if (!r_phase) begin
                        // second product of each lane, subtracted
                        n_phase             = 1'b1;
                        n_mcand[LANE_DEN]   = WIDE_W'(op_sx);
                        n_mult[LANE_DEN]    = op_sx;
                        n_mcand[LANE_SLOPE] = WIDE_W'(op_sx);
                        n_mult[LANE_SLOPE]  = OPND_W'(op_sy);
                        n_mcand[LANE_ICPT]  = WIDE_W'(op_sx);
                        n_mult[LANE_ICPT]   = op_sxy;
                    end else begin
                        n_state = S_ABS;
                    end
                end
            end

            S_ABS: begin
                if (den_zero) begin
                    // fewer than two distinct x values
                    n_out.intercept   = '0;
                    n_out.slope       = '0;
                    n_out.singular    = 1'b1;
                    n_out.overflowed  = r_full;
                    n_out.points_used = COUNT_OUT_W'(r_count);
                    n_out_valid       = 1'b1;
                    n_count           = '0;
                    n_full            = 1'b0;
                    n_sum_x           = '0;
                    n_sum_y           = '0;
                    n_sum_xy          = '0;
                    n_sum_xx          = '0;
                    n_state           = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end

            S_DIV: begin
                if (div_slope_done && div_icpt_done) begin
                    n_out.intercept   = quot_icpt;
                    n_out.slope       = quot_slope;
                    n_out.singular    = 1'b0;
                    n_out.overflowed  = r_full;
                    n_out.points_used = COUNT_OUT_W'(r_count);
                    n_out_valid       = 1'b1;
                    n_count           = '0;
                    n_full            = 1'b0;
                    n_sum_x           = '0;
                    n_sum_y           = '0;
                    n_sum_xy          = '0;
                    n_sum_xx          = '0;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_full      <= 1'b0;
            r_last      <= 1'b0;
            r_bit       <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_xy    <= '0;
            r_sum_xx    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_full      <= n_full;
            r_last      <= n_last;
            r_bit       <= n_bit;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_sum_xy    <= n_sum_xy;
            r_sum_xx    <= n_sum_xx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mac_mcand  <= n_mac_mcand;
        r_mac_mult_y <= n_mac_mult_y;
        r_mac_mult_x <= n_mac_mult_x;
        r_mcand      <= n_mcand;
        r_mult       <= n_mult;
        r_acc        <= n_acc;
        r_out        <= n_out;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

### src/llsf_checker.sv
module llsf_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input llsf_pkg::t_sample     i_sample,
    input logic                  o_result_valid,
    input llsf_pkg::t_fit_result o_result
);
    import llsf_pkg::*;

    // a singular fit reports zero coefficients
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.singular |-> o_result.intercept == '0 && o_result.slope == '0)
        else $error("singular fit with nonzero coefficients");

    // a pair without the last mark never produces a result
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_sample.last_point |=> !o_result_valid)
        else $error("result after a pair that was not last");

    // results come out only when the block has gone idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // busy is raised only by an accepted transaction
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

endmodule

bind linear_least_squares_fit_core llsf_checker u_llsf_checker (.*);
